FILE: hdl/next_anniversary_search_assert.svh
// Assertion macros for the next-anniversary search block.
// NAS_ASSERT_IMP checks a consequence in the same cycle, NAS_ASSERT_NXT in the next cycle.
`ifndef NEXT_ANNIVERSARY_SEARCH_ASSERT_SVH
`define NEXT_ANNIVERSARY_SEARCH_ASSERT_SVH

`ifndef SYNTH

`define NAS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("next_anniversary_search: same-cycle check failed");

`define NAS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next_anniversary_search: next-cycle check failed");

`else

`define NAS_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define NAS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/nas_pkg.sv
package nas_pkg;

  // Field widths
  localparam int unsigned MonthW   = 4;
  localparam int unsigned DayW     = 5;
  localparam int unsigned YearW    = 14;
  localparam int unsigned DaysW    = 9;
  localparam int unsigned AgeW     = 15;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 14;

  // Entry index wraps at this count
  localparam int unsigned MaxEntries = 16384;
  localparam int unsigned SlotW      = $clog2(MaxEntries);

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    CfgTodayMonth = 2'd0,
    CfgTodayDay   = 2'd1,
    CfgTodayYear  = 2'd2
  } cfg_reg_e;

  typedef logic [MonthW-1:0] month_t;
  typedef logic [DayW-1:0]   day_t;
  typedef logic [YearW-1:0]  year_t;

  // Days before the first of month m, month numbers past 12 run on as 31-day months
  function automatic logic [9:0] days_before(input month_t m, input logic leap);
    logic [9:0] d;
    case (m)
      4'd0:    d = 10'd0;
      4'd1:    d = 10'd0;
      4'd2:    d = 10'd31;
      4'd3:    d = 10'd59;
      4'd4:    d = 10'd90;
      4'd5:    d = 10'd120;
      4'd6:    d = 10'd151;
      4'd7:    d = 10'd181;
      4'd8:    d = 10'd212;
      4'd9:    d = 10'd243;
      4'd10:   d = 10'd273;
      4'd11:   d = 10'd304;
      4'd12:   d = 10'd334;
      4'd13:   d = 10'd365;
      4'd14:   d = 10'd396;
      default: d = 10'd427;
    endcase
    if ((m > 4'd2) && leap) begin
      d = d + 10'd1;
    end
    return d;
  endfunction

  // Same position with month 0 taken as a 31-day month ahead of January
  function automatic logic [9:0] month_pos(input month_t m, input logic leap);
    logic [9:0] p;
    if (m == 4'd0) begin
      p = 10'd0;
    end else begin
      p = days_before(m, leap) + 10'd31;
    end
    return p;
  endfunction

endpackage

FILE: hdl/nas_if.sv
// Anniversary entry channel
interface nas_item_if;
  import nas_pkg::*;

  logic   valid;
  logic   ready;
  logic   first;
  month_t event_month;
  day_t   event_day;
  year_t  origin_year;

  modport source (output valid, output first, output event_month, output event_day,
                  output origin_year, input ready);
  modport sink   (input valid, input first, input event_month, input event_day,
                  input origin_year, output ready);
endinterface

// Result channel
interface nas_result_if;
  import nas_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [DaysW-1:0]       days_ahead;
  logic signed [AgeW-1:0] age_then;
  logic [SlotW-1:0]       best_slot;
  logic [DaysW-1:0]       best_count;
  logic signed [AgeW-1:0] best_years;

  modport source (output valid, output days_ahead, output age_then, output best_slot,
                  output best_count, output best_years, input ready);
  modport sink   (input valid, input days_ahead, input age_then, input best_slot,
                  input best_count, input best_years, output ready);
endinterface

FILE: hdl/next_anniversary_search.sv
// Nearest-anniversary search. Today's date is set through the write port (index 0 month,
// 1 day, 2 year). Every accepted entry produces one registered result in the next cycle: the days to
// its next occurrence (0..366, a date equal to today counts as next year), the age reached
// then, and the nearest entry seen since reset or the last request with first set (ties
// keep the earlier entry). One entry is taken every cycle; the only limit is the single
// result register, which still takes a new request while the result is being read out.
// Leap flags for this year and next are worked out when the year is written.
module next_anniversary_search (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nas_pkg::CfgDataW-1:0]  cfg_data_i,
  nas_item_if.sink                      in_i,
  nas_result_if.source                  out_o
);
  import nas_pkg::*;

  `include "next_anniversary_search_assert.svh"

  localparam logic [14:0] Inv25      = 15'd23593;  // inverse of 25 modulo 2^15
  localparam logic [14:0] Div25Limit = 15'd1310;   // (2^15 - 1) / 25
  localparam logic [9:0]  NoneYet    = 10'd1000;
  localparam month_t      LastMonth  = 4'd12;
  localparam month_t      YearEnd    = 4'd13;
  localparam logic signed [11:0] DaysMax = 12'sd366;
  localparam logic signed [15:0] AgeMin  = -16'sd9999;
  localparam logic signed [15:0] AgeMax  = 16'sd10000;

  // Gregorian leap test: divisible by 25 through the modular inverse
  function automatic logic leap_of(input logic [14:0] y);
    logic [29:0] prod;
    logic        div25;
    prod  = y * Inv25;
    div25 = (prod[14:0] <= Div25Limit);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // Configuration
  month_t today_month_q;
  day_t   today_day_q;
  year_t  today_year_q;
  logic   leap_this_q;
  logic   leap_next_q;
  logic [14:0] wr_year;

  assign wr_year = {1'b0, cfg_data_i[YearW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      today_month_q <= 4'd1;
      today_day_q   <= 5'd1;
      today_year_q  <= 14'd2000;
      leap_this_q   <= 1'b1;
      leap_next_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgTodayMonth: today_month_q <= cfg_data_i[MonthW-1:0];
        CfgTodayDay:   today_day_q   <= cfg_data_i[DayW-1:0];
        CfgTodayYear: begin
          today_year_q <= cfg_data_i[YearW-1:0];
          leap_this_q  <= leap_of(wr_year);
          leap_next_q  <= leap_of(wr_year + 15'd1);
        end
        default: ;
      endcase
    end
  end

  // Handshake
  logic out_valid_q;
  logic in_acc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // Day count to the next occurrence
  logic              later;
  logic [9:0]        pos_today;
  logic [9:0]        pos_event;
  logic [9:0]        pos_end;
  logic [9:0]        before_next;
  logic signed [11:0] base;
  logic signed [11:0] total;
  logic [DaysW-1:0]  days;

  always_comb begin
    later = (today_month_q < in_i.event_month) ||
            ((today_month_q == in_i.event_month) && (today_day_q < in_i.event_day));
    pos_today   = month_pos(today_month_q, leap_this_q);
    pos_event   = month_pos(in_i.event_month, leap_this_q);
    pos_end     = month_pos(YearEnd, leap_this_q);
    before_next = days_before(in_i.event_month, leap_next_q);
    if (later) begin
      base = $signed({2'b00, pos_event}) - $signed({2'b00, pos_today});
    end else if (today_month_q <= LastMonth) begin
      base = $signed({2'b00, pos_end}) - $signed({2'b00, pos_today}) +
             $signed({2'b00, before_next});
    end else begin
      base = 12'sd31 + $signed({2'b00, before_next});
    end
    total = base + $signed({7'b0, in_i.event_day}) - $signed({7'b0, today_day_q});
    if (total < 12'sd0) begin
      days = '0;
    end else if (total > DaysMax) begin
      days = DaysMax[DaysW-1:0];
    end else begin
      days = total[DaysW-1:0];
    end
  end

  // Age reached on that day
  logic signed [15:0]     age_raw;
  logic signed [AgeW-1:0] age;

  always_comb begin
    age_raw = $signed({2'b00, today_year_q}) + $signed({15'b0, !later}) -
              $signed({2'b00, in_i.origin_year});
    if (age_raw < AgeMin) begin
      age = AgeMin[AgeW-1:0];
    end else if (age_raw > AgeMax) begin
      age = AgeMax[AgeW-1:0];
    end else begin
      age = age_raw[AgeW-1:0];
    end
  end

  // Running minimum, first flag restarts it
  logic [SlotW-1:0]       count_q, count_d;
  logic [9:0]             near_days_q, near_days_d;
  logic [SlotW-1:0]       near_slot_q, near_slot_d;
  logic signed [AgeW-1:0] near_age_q, near_age_d;
  logic [SlotW-1:0]       slot;
  logic [9:0]             near_cmp;

  always_comb begin
    slot        = in_i.first ? '0 : count_q;
    near_cmp    = in_i.first ? NoneYet : near_days_q;
    near_days_d = in_i.first ? NoneYet : near_days_q;
    near_slot_d = in_i.first ? '0 : near_slot_q;
    near_age_d  = in_i.first ? '0 : near_age_q;
    if ({1'b0, days} < near_cmp) begin
      near_days_d = {1'b0, days};
      near_slot_d = slot;
      near_age_d  = age;
    end
    count_d = slot + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      near_days_q <= NoneYet;
      near_slot_q <= '0;
      near_age_q  <= '0;
    end else if (in_acc) begin
      count_q     <= count_d;
      near_days_q <= near_days_d;
      near_slot_q <= near_slot_d;
      near_age_q  <= near_age_d;
    end
  end

  // Result register
  logic [DaysW-1:0]       days_q;
  logic signed [AgeW-1:0] age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_acc || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      days_q <= days;
      age_q  <= age;
    end
  end

  // The best fields are the search state itself, so they match the result until the next request is taken
  assign out_o.valid      = out_valid_q;
  assign out_o.days_ahead = days_q;
  assign out_o.age_then   = age_q;
  assign out_o.best_slot  = near_slot_q;
  assign out_o.best_count = near_days_q[DaysW-1:0];
  assign out_o.best_years = near_age_q;

  // Checks
  `NAS_ASSERT_NXT(a_acc_gives_result, clk_i, rst_ni, in_acc, out_valid_q)
  `NAS_ASSERT_IMP(a_days_range, clk_i, rst_ni, out_valid_q, days_q <= 9'd366)
  `NAS_ASSERT_IMP(a_best_not_worse, clk_i, rst_ni, out_valid_q, near_days_q <= {1'b0, days_q})
  `NAS_ASSERT_IMP(a_age_range, clk_i, rst_ni, out_valid_q, (age_q >= -15'sd9999) && (age_q <= 15'sd10000))

endmodule

FILE: dv/next_anniversary_search_tb.sv
`timescale 1ns / 100ps

module next_anniversary_search_tb;
  import nas_pkg::*;

  typedef struct packed {
    logic [DaysW-1:0]       days;
    logic signed [AgeW-1:0] age;
    logic [SlotW-1:0]       slot;
    logic [DaysW-1:0]       count;
    logic signed [AgeW-1:0] years;
  } anniv_result_t;

  // Scoreboard: mirrors today's date and the running nearest-entry search
  class anniversary_scoreboard;
    int unsigned   cur_month;
    int unsigned   cur_day;
    int unsigned   cur_year;
    int unsigned   next_slot;
    int            near_days;
    int unsigned   near_slot;
    int            near_age;
    anniv_result_t pending[$];
    int unsigned   errors;
    int unsigned   entries;
    int unsigned   checked;
    int unsigned   restarts;

    function void reset_state();
      cur_month = 1;
      cur_day   = 1;
      cur_year  = 2000;
      next_slot = 0;
      near_days = 1000;
      near_slot = 0;
      near_age  = 0;
    endfunction

    function void set_today(int unsigned m, int unsigned d, int unsigned y);
      cur_month = m;
      cur_day   = d;
      cur_year  = y;
    endfunction

    // Gregorian month length; any month number outside the short ones is 31 days
    function int month_days(int unsigned m, int unsigned y);
      bit leap;
      leap = (y % 100 == 0) ? (y % 400 == 0) : (y % 4 == 0);
      if (m == 2) return leap ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    // Work out the days ahead, the age and the updated nearest entry
    function void note_entry(logic f, month_t m, day_t d, year_t y);
      bit            later;
      int            days;
      int            age;
      int unsigned   i;
      int unsigned   slot;
      anniv_result_t r;
      later = (cur_month < m) || (cur_month == m && cur_day < d);
      entries++;
      if (f) begin
        restarts++;
        next_slot = 0;
        near_days = 1000;
        near_slot = 0;
        near_age  = 0;
      end
      days = 0;
      if (later) begin
        for (i = cur_month + 1; i < m; i++) days += month_days(i, cur_year);
        days += int'(d);
        if (cur_month == m) days -= int'(cur_day);
        else days += month_days(cur_month, cur_year) - int'(cur_day);
      end else begin
        for (i = cur_month + 1; i < 13; i++) days += month_days(i, cur_year);
        days += month_days(cur_month, cur_year) - int'(cur_day) + int'(d);
        for (i = 1; i < m; i++) days += month_days(i, cur_year + 1);
      end
      if (days < 0) days = 0;
      if (days > 366) days = 366;
      age = int'(cur_year) + (later ? 0 : 1) - int'(y);
      if (age < -9999) age = -9999;
      if (age > 10000) age = 10000;
      slot = next_slot % MaxEntries;
      // strictly smaller only: the earlier entry keeps a tie
      if (days < near_days) begin
        near_days = days;
        near_slot = slot;
        near_age  = age;
      end
      next_slot = (slot + 1) % MaxEntries;
      r.days  = days[DaysW-1:0];
      r.age   = age[AgeW-1:0];
      r.slot  = near_slot[SlotW-1:0];
      r.count = near_days[DaysW-1:0];
      r.years = near_age[AgeW-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [DaysW-1:0] days, logic signed [AgeW-1:0] age,
                               logic [SlotW-1:0] slot, logic [DaysW-1:0] count,
                               logic signed [AgeW-1:0] years);
      anniv_result_t want;
      if (pending.size() == 0) begin
        $error("result arrived with no entry outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (days !== want.days) begin
        $error("days_ahead: expected %0d, got %0d", want.days, days);
        errors++;
      end
      if (age !== want.age) begin
        $error("age_then: expected %0d, got %0d", $signed(want.age), age);
        errors++;
      end
      if (slot !== want.slot) begin
        $error("best_slot: expected %0d, got %0d", want.slot, slot);
        errors++;
      end
      if (count !== want.count) begin
        $error("best_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
      if (years !== want.years) begin
        $error("best_years: expected %0d, got %0d", $signed(want.years), years);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  nas_item_if   entry_if();
  nas_result_if result_if();

  anniversary_scoreboard sb = new;

  bit          idle_in;
  bit          stall_out;
  int unsigned settings;

  next_anniversary_search dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (entry_if),
    .out_o     (result_if)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Monitor both channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (entry_if.valid && entry_if.ready) begin
        sb.note_entry(entry_if.first, entry_if.event_month, entry_if.event_day,
                      entry_if.origin_year);
      end
      if (result_if.valid && result_if.ready) begin
        sb.check_result(result_if.days_ahead, result_if.age_then, result_if.best_slot,
                        result_if.best_count, result_if.best_years);
      end
    end
  end

  // Result side back-pressure, in bursts
  initial begin
    result_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (stall_out && $urandom_range(0, 4) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        result_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Write all three date registers, one per cycle
  task automatic write_today(input int unsigned m, input int unsigned d,
                             input int unsigned y);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgTodayMonth;
    cfg_data_i <= CfgDataW'(m);
    @(posedge clk_i);
    cfg_idx_i  <= CfgTodayDay;
    cfg_data_i <= CfgDataW'(d);
    @(posedge clk_i);
    cfg_idx_i  <= CfgTodayYear;
    cfg_data_i <= CfgDataW'(y);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_today(m, d, y);
    settings++;
  endtask

  // Present one request and hold it until accepted
  task automatic send_entry(input logic f, input month_t m, input day_t d, input year_t y);
    if (idle_in && $urandom_range(0, 4) == 0) begin
      entry_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    entry_if.valid       <= 1'b1;
    entry_if.first       <= f;
    entry_if.event_month <= m;
    entry_if.event_day   <= d;
    entry_if.origin_year <= y;
    @(posedge clk_i);
    while (!entry_if.ready) @(posedge clk_i);
  endtask

  // One edge first so the monitor has noted the last accepted request
  task automatic wait_for_results();
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    int unsigned tm;
    int unsigned td;
    int unsigned ty;
    int unsigned pick;
    int          oy;
    logic        f;
    month_t      m;
    day_t        d;

    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CfgTodayMonth;
    cfg_data_i           <= '0;
    entry_if.valid       <= 1'b0;
    entry_if.first       <= 1'b0;
    entry_if.event_month <= '0;
    entry_if.event_day   <= '0;
    entry_if.origin_year <= '0;
    idle_in   = 1'b1;
    stall_out = 1'b1;
    settings  = 0;
    sb.reset_state();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset date 1 Jan 2000, no first flag yet
    send_entry(1'b0, 4'd1, 5'd1, 14'd2000);    // today itself -> a full leap year
    send_entry(1'b0, 4'd12, 5'd31, 14'd0);
    send_entry(1'b0, 4'd0, 5'd0, 14'd16383);   // age clamps low
    send_entry(1'b0, 4'd15, 5'd31, 14'd0);     // day count clamps high
    entry_if.valid <= 1'b0;
    wait_for_results();

    // Latest date allowed; next year is a 400-year leap year
    write_today(12, 31, 9999);
    send_entry(1'b1, 4'd12, 5'd31, 14'd0);     // age at its ceiling
    send_entry(1'b0, 4'd1, 5'd1, 14'd9999);
    send_entry(1'b0, 4'd2, 5'd29, 14'd5000);
    send_entry(1'b0, 4'd0, 5'd0, 14'd100);     // zero days ahead
    send_entry(1'b0, 4'd0, 5'd0, 14'd200);     // tie, earlier entry stays
    send_entry(1'b0, 4'd13, 5'd5, 14'd1);
    entry_if.valid <= 1'b0;
    wait_for_results();

    // Year zero, itself a leap year
    write_today(1, 1, 0);
    send_entry(1'b1, 4'd3, 5'd1, 14'd0);
    send_entry(1'b0, 4'd2, 5'd29, 14'd16383);
    entry_if.valid <= 1'b0;
    wait_for_results();

    // Century year without a leap day
    write_today(2, 28, 1900);
    send_entry(1'b1, 4'd3, 5'd1, 14'd1850);
    send_entry(1'b0, 4'd2, 5'd29, 14'd1899);   // invalid date, still counted
    send_entry(1'b0, 4'd2, 5'd28, 14'd1900);
    entry_if.valid <= 1'b0;
    wait_for_results();

    write_today(3, 15, 2024);
    send_entry(1'b1, 4'd2, 5'd29, 14'd1996);
    send_entry(1'b0, 4'd3, 5'd15, 14'd2024);
    send_entry(1'b0, 4'd3, 5'd0, 14'd2030);
    send_entry(1'b0, 4'd3, 5'd16, 14'd2023);
    entry_if.valid <= 1'b0;
    wait_for_results();

    // Random phases, each under its own date
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: write_today(12, 31, 9999);
        1: write_today(1, 1, 0);
        2: write_today(2, 29, 2000);
        3: write_today(2, 28, 2100);
        default: begin
          tm = $urandom_range(1, 12);
          ty = $urandom_range(0, 9999);
          write_today(tm, $urandom_range(1, sb.month_days(tm, ty)), ty);
        end
      endcase
      idle_in   = (p < 7) && (p != 5);
      stall_out = (p < 7) && (p != 4);
      tm = sb.cur_month;
      td = sb.cur_day;
      ty = sb.cur_year;
      for (int k = 0; k < 75; k++) begin
        // hold off once until the block has drained
        if (p == 3 && k == 40) begin
          entry_if.valid <= 1'b0;
          wait_for_results();
        end
        pick = $urandom_range(0, 99);
        f    = ($urandom_range(0, 15) == 0);
        if (pick < 15) begin
          // noise over the whole field range
          m  = month_t'($urandom);
          d  = day_t'($urandom);
          oy = $urandom_range(0, 16383);
        end else begin
          if (pick < 35) begin
            // today or a day either side
            m = month_t'(tm);
            d = day_t'(int'(td) + $urandom_range(0, 2) - 1);
          end else begin
            m = month_t'($urandom_range(1, 12));
            d = day_t'($urandom_range(1, sb.month_days(m, ty)));
          end
          if ($urandom_range(0, 3) == 0) oy = $urandom_range(0, 9999);
          else oy = int'(ty) - int'($urandom_range(0, 110));
          if (oy < 0) oy = 0;
        end
        send_entry(f, m, d, year_t'(oy));
      end
      entry_if.valid <= 1'b0;
      wait_for_results();
    end

    repeat (5) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d entries (%0d results checked) under %0d date settings,",
             sb.entries, sb.checked, settings + 1);
    $display("with %0d search restarts, leap and century edge dates and random stalls.",
             sb.restarts);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
